>>> src/cit_pkg.sv
`default_nettype none
package cit_pkg;
    localparam int TableDepthDefault = 64;
    localparam int CoordBitsDefault = 32;
    localparam int FieldCoordBits = 32;
    localparam int CountBits = 7;
    localparam int StatusBits = 2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_WRITE,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic write_back;
        logic out_load;
    } cmd_bus_t;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic bad;
        logic scan_last;
        logic changed;
        logic have_free;
    } stat_bus_t;
endpackage
`default_nettype wire

>>> src/cit_ram.sv
`default_nettype none
module cit_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> src/cit_ctrl.sv
`default_nettype none
module cit_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic              out_busy,
    input  wire cit_pkg::stat_bus_t st,
    output cit_pkg::cmd_bus_t      cmd,
    output logic                   idle
);
    import cit_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        idle = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // decide after the item is latched
                if (st.is_query || st.bad)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    if (st.changed)
                    begin
                        // union grew: another pass may pick up more
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.write_back = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> src/cit_dp.sv
`default_nettype none
module cit_dp #(
    parameter int TableDepth = cit_pkg::TableDepthDefault,
    parameter int CoordBits = cit_pkg::CoordBitsDefault
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire cit_pkg::cmd_bus_t                  cmd,
    input  wire logic                               in_cmd,
    input  wire logic [cit_pkg::FieldCoordBits-1:0] in_start,
    input  wire logic [cit_pkg::FieldCoordBits-1:0] in_end,
    output cit_pkg::stat_bus_t                      st,
    output logic [cit_pkg::CountBits-1:0]           res_count,
    output logic [cit_pkg::StatusBits-1:0]          res_status
);
    import cit_pkg::*;

    localparam int AW = $clog2(TableDepth);
    localparam int CW = $clog2(TableDepth + 1);
    localparam int UB = (CoordBits < FieldCoordBits) ? CoordBits : FieldCoordBits;
    localparam logic [CoordBits-1:0] CMax = '1;

    logic [CoordBits-1:0] s_reg, e_reg;
    logic                 query_reg;
    logic [TableDepth-1:0] valid_reg;
    logic [CW-1:0]        count_reg;
    logic [AW:0]          idx_reg;
    logic                 rd_pend_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic                 changed_reg;
    logic [StatusBits-1:0] status_reg;
    logic [2*CoordBits-1:0] rdata;
    logic [CoordBits-1:0] rs, re;
    logic                 join_hit;
    logic [AW-1:0]        free_idx;
    logic                 have_free;
    logic [StatusBits-1:0] res_status_next;
    logic [CoordBits-1:0] s_in, e_in;

    always_comb
    begin
        s_in = '0;
        e_in = '0;
        s_in[UB-1:0] = in_start[UB-1:0];
        e_in[UB-1:0] = in_end[UB-1:0];
    end

    cit_ram #(.Width(2*CoordBits), .Depth(TableDepth)) u_ram (
        .clk  (clk),
        .we   (cmd.write_back && have_free),
        .waddr(free_idx),
        .wdata({e_reg, s_reg}),
        .raddr(idx_reg[AW-1:0]),
        .rdata(rdata)
    );

    assign rs = rdata[CoordBits-1:0];
    assign re = rdata[2*CoordBits-1:CoordBits];
    assign join_hit = rd_pend_reg && valid_reg[rd_idx_reg] &&
        ((s_reg <= re && rs <= e_reg) ||
         (e_reg != CMax && e_reg + 1'b1 == rs) ||
         (re != CMax && re + 1'b1 == s_reg));

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        have_free = 1'b0;
        for (int i = TableDepth - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = AW'(i);
                have_free = 1'b1;
            end
        end
    end

    assign st.is_query = query_reg;
    assign st.bad = (s_reg > e_reg);
    assign st.scan_last = rd_pend_reg && (rd_idx_reg == AW'(TableDepth - 1));
    assign st.changed = changed_reg || join_hit;
    assign st.have_free = have_free;

    always_comb
    begin
        if (query_reg)
        begin
            res_status_next = ST_OK;
        end
        else if (s_reg > e_reg)
        begin
            res_status_next = ST_BAD;
        end
        else if (!have_free)
        begin
            res_status_next = ST_FULL;
        end
        else
        begin
            res_status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
            rd_pend_reg <= 1'b0;
            changed_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
                rd_pend_reg <= 1'b0;
                changed_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (idx_reg < (AW+1)'(TableDepth))
                begin
                    idx_reg <= idx_reg + 1'b1;
                    rd_pend_reg <= 1'b1;
                end
                else
                begin
                    rd_pend_reg <= 1'b0;
                end
                if (join_hit)
                begin
                    valid_reg[rd_idx_reg] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                    changed_reg <= 1'b1;
                end
            end
            if (cmd.write_back && have_free)
            begin
                valid_reg[free_idx] <= 1'b1;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg[AW-1:0];
        if (cmd.load)
        begin
            query_reg <= in_cmd;
            s_reg <= s_in;
            e_reg <= e_in;
        end
        else if (cmd.scan_step && join_hit)
        begin
            if (rs < s_reg)
            begin
                s_reg <= rs;
            end
            if (re > e_reg)
            begin
                e_reg <= re;
            end
        end
        // status is kept internally so a result still waiting at the output stays put
        if (cmd.write_back)
        begin
            status_reg <= res_status_next;
        end
        else if (cmd.load)
        begin
            status_reg <= (in_cmd == CMD_QUERY) ? ST_OK : ST_BAD;
        end
        if (cmd.out_load)
        begin
            res_count <= CountBits'(count_reg);
            res_status <= status_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(valid_reg)))
        else $error("count does not match valid bits");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_back && have_free |=> count_reg == $past(count_reg) + 1'b1)
        else $error("write back lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> s_reg <= e_reg)
        else $error("scan with inverted range");
endmodule
`default_nettype wire

>>> src/coalescing_interval_table_core.sv
`default_nettype none
// sequence: a query or rejected insert is latched and delivered; an insert runs a scan pass
//   over the range memory (one entry read per cycle), repeated while the
//   union still grows, then writes back and delivers
// items: one at a time; a new item is taken only after the last result is loaded for output
// reset: rst_n async active low clears valid bits, count and control; memory is not cleared
module coalescing_interval_table_core #(
    parameter int TableDepth = cit_pkg::TableDepthDefault,
    parameter int CoordBits = cit_pkg::CoordBitsDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // range_start[31:0], range_end[63:32]
    input  wire logic        s_tuser,  // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // range_count[6:0], status[8:7], zero pad
);
    import cit_pkg::*;

    cmd_bus_t  cmd;
    stat_bus_t st;
    logic      idle;
    logic      in_fire;
    logic      m_tvalid_reg;
    logic [CountBits-1:0]  res_count;
    logic [StatusBits-1:0] res_status;

    // input transaction only while controller is idle
    assign s_tready = idle;
    assign in_fire = s_tvalid && s_tready;

    cit_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .out_busy(m_tvalid_reg && !m_tready),
        .st      (st),
        .cmd     (cmd),
        .idle    (idle)
    );

    cit_dp #(.TableDepth(TableDepth), .CoordBits(CoordBits)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_cmd    (s_tuser),
        .in_start  (s_tdata[31:0]),
        .in_end    (s_tdata[63:32]),
        .st        (st),
        .res_count (res_count),
        .res_status(res_status)
    );

    // output register: result waits here while the next item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {7'd0, res_status, res_count};

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result overwritten");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("accepted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output dropped");
endmodule
`default_nettype wire

>>> tb/coalescing_interval_table_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module coalescing_interval_table_core_tb;
    import cit_pkg::*;

    localparam int Depth = 64;
    localparam logic [32:0] CoordTop = 33'h0FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // range_start[31:0], range_end[63:32]
    logic        s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // range_count[6:0], status[8:7], zero pad

    coalescing_interval_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // one expected answer per accepted transaction
    typedef struct packed {
        logic [6:0] count;
        status_t    status;
    } answer_t;

    // one directed row: command, range and, where obvious, the answer
    typedef struct {
        cmd_t        op;
        logic [31:0] lo;
        logic [31:0] hi;
        bit          typed;
        answer_t     ans;
    } row_t;

    // shadow copy of the interval table
    logic [31:0] span_lo [Depth];
    logic [31:0] span_hi [Depth];
    bit          span_used [Depth];
    int          span_count;

    answer_t answer_q[$];
    int      error_count;
    int      item_count;
    int      full_seen;
    int      bad_seen;
    int      merge_seen;
    bit      quiet_in;
    bit      quiet_out;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // two closed ranges overlap or abut; the abut test stops at the top coordinate
    function automatic bit spans_touch(logic [31:0] a_lo, logic [31:0] a_hi,
                                       logic [31:0] b_lo, logic [31:0] b_hi);
        if (a_lo <= b_hi && b_lo <= a_hi)
            return 1'b1;
        if ({1'b0, a_hi} != CoordTop && {1'b0, a_hi} + 33'd1 == {1'b0, b_lo})
            return 1'b1;
        if ({1'b0, b_hi} != CoordTop && {1'b0, b_hi} + 33'd1 == {1'b0, a_lo})
            return 1'b1;
        return 1'b0;
    endfunction

    // apply one command to the shadow table and return the answer it gives
    function automatic answer_t table_update(cmd_t op, logic [31:0] lo, logic [31:0] hi);
        answer_t r;
        bit      grew;
        int      slot;
        r.status = ST_OK;
        if (op == CMD_INSERT)
        begin
            if (lo > hi)
            begin
                r.status = ST_BAD;
            end
            else
            begin
                // sweep until the union stops growing
                grew = 1'b1;
                while (grew)
                begin
                    grew = 1'b0;
                    for (int i = 0; i < Depth; i++)
                    begin
                        if (span_used[i] && spans_touch(lo, hi, span_lo[i], span_hi[i]))
                        begin
                            if (span_lo[i] < lo) lo = span_lo[i];
                            if (span_hi[i] > hi) hi = span_hi[i];
                            span_used[i] = 1'b0;
                            span_count--;
                            grew = 1'b1;
                            merge_seen++;
                        end
                    end
                end
                slot = -1;
                for (int i = 0; i < Depth; i++)
                begin
                    if (!span_used[i] && slot < 0) slot = i;
                end
                if (slot < 0)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    span_lo[slot] = lo;
                    span_hi[slot] = hi;
                    span_used[slot] = 1'b1;
                    span_count++;
                end
            end
        end
        r.count = span_count[6:0];
        return r;
    endfunction

    // hand one transaction to the block, then predict its answer
    task automatic send_item(cmd_t op, logic [31:0] lo, logic [31:0] hi,
                             bit typed, answer_t ans);
        answer_t p;
        while (!quiet_in && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {hi, lo};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        p = table_update(op, lo, hi);
        if (typed && p != ans)
        begin
            $error("directed row %0d answer: expected %h, predicted %h", item_count, ans, p);
            error_count++;
        end
        if (p.status == ST_FULL) full_seen++;
        if (p.status == ST_BAD) bad_seen++;
        answer_q.push_back(typed ? ans : p);
        item_count++;
    endtask

    // receiver with random stalls
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= quiet_out || ($urandom_range(99) >= 11);
    end

    // compare every answer with the oldest prediction
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answer_q.size() == 0)
            begin
                $error("answer %h with nothing outstanding", m_tdata);
                error_count++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (m_tdata[6:0] !== want.count)
                begin
                    $error("range_count: expected %0d, actual %0d", want.count, m_tdata[6:0]);
                    error_count++;
                end
                if (m_tdata[8:7] !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[8:7]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        row_t        rows[$];
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] base;
        int          mode;
        int          width;
        int          wait_cycles;

        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_QUERY;
        m_tready = 1'b0;
        error_count = 0;
        item_count = 0;
        full_seen = 0;
        bad_seen = 0;
        merge_seen = 0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        span_count = 0;
        for (int i = 0; i < Depth; i++)
        begin
            span_used[i] = 1'b0;
            span_lo[i] = '0;
            span_hi[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: empty table, extremes, rejection, touching, top coordinate
        rows = '{
            '{CMD_QUERY,  32'h0, 32'h0, 1'b1, '{7'd0, ST_OK}},
            '{CMD_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'h5, 32'h4, 1'b1, '{7'd0, ST_BAD}},
            '{CMD_INSERT, 32'hFFFF_FFFF, 32'h0, 1'b1, '{7'd0, ST_BAD}},
            '{CMD_INSERT, 32'h0, 32'h0, 1'b1, '{7'd1, ST_OK}},
            '{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{7'd2, ST_OK}},
            '{CMD_INSERT, 32'h1, 32'h1, 1'b0, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'h3, 32'h9, 1'b0, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'h2, 32'h2, 1'b0, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFD, 1'b0, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'h100, 32'h200, 1'b0, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'h300, 32'h400, 1'b0, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'h150, 32'h350, 1'b0, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'h7, 32'h7, 1'b0, '{7'd0, ST_OK}},
            '{CMD_QUERY,  32'hAAAA_5555, 32'h5555_AAAA, 1'b0, '{7'd0, ST_OK}},
            '{CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b0, '{7'd0, ST_OK}},
            '{CMD_QUERY,  32'h0, 32'h0, 1'b1, '{7'd1, ST_OK}}
        };
        foreach (rows[i])
            send_item(rows[i].op, rows[i].lo, rows[i].hi, rows[i].typed, rows[i].ans);

        // insert isolated points, more of them than the table has slots
        for (int i = 0; i < Depth + 3; i++)
            send_item(CMD_INSERT, 32'h8000_0000 + 32'(i * 4), 32'h8000_0000 + 32'(i * 4),
                      1'b0, '0);
        send_item(CMD_INSERT, 32'h8000_0001, 32'h8000_0002, 1'b0, '0);
        send_item(CMD_INSERT, 32'h10, 32'h10, 1'b0, '0);

        // random part; a quiet stretch in the middle, the whole coordinate range inserted now and then
        for (int n = 0; n < 1800; n++)
        begin
            quiet_in = (n >= 700 && n < 950);
            quiet_out = quiet_in;
            mode = $urandom_range(99);
            base = (n / 300) % 2 ? 32'hFFFF_FF00 : 32'h0000_0000;
            width = $urandom_range(3) == 0 ? 15 : 3;
            lo = base + $urandom_range(255);
            hi = lo + $urandom_range(width);
            if (hi < lo) hi = 32'hFFFF_FFFF;
            if (mode < 10)
                send_item(CMD_QUERY, $urandom, $urandom, 1'b0, '0);
            else if (mode < 16)
                send_item(CMD_INSERT, $urandom, $urandom, 1'b0, '0);
            else if (mode < 18)
                send_item(CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
            else if (mode < 22)
                send_item(CMD_INSERT, hi + 32'd1 + 32'($urandom_range(1)), lo, 1'b0, '0);
            else
                send_item(CMD_INSERT, lo, hi, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;

        // drain, then wait for the last write back
        wait_cycles = 0;
        while (answer_q.size() != 0 && wait_cycles < 200_000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (answer_q.size() != 0)
        begin
            $error("%0d answers never arrived", answer_q.size());
            error_count++;
        end
        repeat (Depth + 10) @(posedge clk);
        if (answer_q.size() != 0) error_count++;

        $display("covered %0d transactions: %0d merges, %0d dropped as full, %0d rejected",
                 item_count, merge_seen, full_seen, bad_seen);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
